// File: hdl/kpq_pkg.sv
// Shared key codes, limits and the accumulator state type for the keypad parser.
`timescale 1ns / 1ps

package kpq_pkg;

    localparam logic [7:0] KEY_ENTER = 8'h23;
    localparam logic [7:0] KEY_STAR  = 8'h2A;
    localparam logic [7:0] KEY_ZERO  = 8'h30;
    localparam logic [7:0] KEY_NINE  = 8'h39;

    localparam logic [9:0] INT_MAX_ACC = 10'd1023;
    localparam logic [9:0] Q_MAX_MAG   = 10'd512;

    // floor(g * 256 / 100) equals (g * FRAC_RECIP) >> FRAC_SHIFT for g in 0..99.
    localparam logic [12:0] FRAC_RECIP = 13'd5243;
    localparam int          FRAC_SHIFT = 11;

    typedef struct packed {
        logic [9:0] integer_part;
        logic [6:0] fraction_part;
        logic [1:0] fraction_digits;
        logic       negative_flag;
        logic       point_seen;
        logic       digit_seen;
    } kpq_state_t;

endpackage

// File: hdl/kpq_accum.sv
// Entry state registers and their per-key update.
`timescale 1ns / 1ps

module kpq_accum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    input  logic [7:0]        key,
    output kpq_pkg::kpq_state_t state
);

    kpq_pkg::kpq_state_t state_reg;
    kpq_pkg::kpq_state_t state_next;

    logic [3:0]  digit;
    logic [13:0] int_wide;
    logic [6:0]  frac_new;

    always_comb
    begin
        digit      = 4'(key - kpq_pkg::KEY_ZERO);
        int_wide   = 14'(state_reg.integer_part) * 14'd10 + 14'(digit);
        frac_new   = 7'(state_reg.fraction_part * 7'd10 + 7'(digit));
        state_next = state_reg;
        case (key)
            kpq_pkg::KEY_ENTER:
            begin
                state_next = '0;
            end
            kpq_pkg::KEY_STAR:
            begin
                if (!state_reg.digit_seen && !state_reg.negative_flag)
                begin
                    state_next.negative_flag = 1'b1;
                end
                else if (state_reg.digit_seen && !state_reg.point_seen)
                begin
                    state_next.point_seen = 1'b1;
                end
            end
            default:
            begin
                if (key inside {[kpq_pkg::KEY_ZERO:kpq_pkg::KEY_NINE]})
                begin
                    state_next.digit_seen = 1'b1;
                    if (state_reg.point_seen)
                    begin
                        if (state_reg.fraction_digits < 2'd2)
                        begin
                            state_next.fraction_part   = frac_new;
                            state_next.fraction_digits = state_reg.fraction_digits + 2'd1;
                        end
                    end
                    else if (int_wide > 14'(kpq_pkg::INT_MAX_ACC))
                    begin
                        state_next.integer_part = kpq_pkg::INT_MAX_ACC;
                    end
                    else
                    begin
                        state_next.integer_part = int_wide[9:0];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (enable)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// File: hdl/kpq_compose.sv
// Converts the entry state into a clamped signed Q8.8 value.
`timescale 1ns / 1ps

module kpq_compose (
    input  kpq_pkg::kpq_state_t state,
    output logic signed [10:0]  value
);

    logic [6:0]  frac_cents;
    logic [19:0] frac_prod;
    logic [7:0]  frac_q8;
    logic [17:0] magnitude;
    logic [9:0]  mag_sat;
    logic [10:0] mag_ext;

    always_comb
    begin
        // A single fraction digit is scaled to hundredths so one reciprocal serves both cases.
        if (state.fraction_digits == 2'd1)
        begin
            frac_cents = 7'(state.fraction_part * 7'd10);
        end
        else
        begin
            frac_cents = state.fraction_part;
        end
        frac_prod = 20'(frac_cents) * 20'(kpq_pkg::FRAC_RECIP);
        if (state.fraction_digits == 2'd0)
        begin
            frac_q8 = 8'd0;
        end
        else
        begin
            frac_q8 = frac_prod[kpq_pkg::FRAC_SHIFT +: 8];
        end
        magnitude = {state.integer_part, 8'd0} + 18'(frac_q8);
        if (magnitude > 18'(kpq_pkg::Q_MAX_MAG))
        begin
            mag_sat = kpq_pkg::Q_MAX_MAG;
        end
        else
        begin
            mag_sat = magnitude[9:0];
        end
        mag_ext = {1'b0, mag_sat};
        if (state.negative_flag)
        begin
            value = $signed(11'd0 - mag_ext);
        end
        else
        begin
            value = $signed(mag_ext);
        end
    end

endmodule

// File: hdl/keypad_decimal_to_q8_8_parser.sv
// Top level of the keypad decimal entry parser with Q8.8 output.
`timescale 1ns / 1ps

// Accepts one keypad code per cycle. A key is captured in an input register and
// from there applied to the entry state. On '#' the composed value is loaded
// into the result register as the '#' leaves the input register. Digits, stars
// and ignored codes never wait. A '#' waits only while the result register
// still holds an earlier value that the consumer stalls, so the sustained rate
// is one key per cycle whenever the output side keeps up.
module keypad_decimal_to_q8_8_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         key_code,
    input  logic               key_valid,
    output logic               key_stall,
    output logic signed [10:0] value_q88,
    output logic               value_valid,
    input  logic               value_stall
);

    logic [7:0]         key_reg;
    logic               key_valid_reg;
    logic signed [10:0] value_reg;
    logic               value_valid_reg;

    logic               is_enter;
    logic               stage_go;
    logic signed [10:0] composed;

    kpq_pkg::kpq_state_t entry_state;

    assign is_enter  = (key_reg == kpq_pkg::KEY_ENTER);
    assign stage_go  = key_valid_reg && (!is_enter || !value_valid_reg || !value_stall);
    assign key_stall = key_valid_reg && !stage_go;

    kpq_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (stage_go),
        .key    (key_reg),
        .state  (entry_state)
    );

    kpq_compose u_compose (
        .state (entry_state),
        .value (composed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= 1'b0;
        end
        else if (!key_stall)
        begin
            key_valid_reg <= key_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!key_stall && key_valid)
        begin
            key_reg <= key_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_valid_reg <= 1'b0;
        end
        else if (stage_go && is_enter)
        begin
            value_valid_reg <= 1'b1;
        end
        else if (!value_stall)
        begin
            value_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && is_enter)
        begin
            value_reg <= composed;
        end
    end

    assign value_q88   = value_reg;
    assign value_valid = value_valid_reg;

    a_value_range : assert property (@(posedge clk) disable iff (!rst_n)
        value_valid |-> (value_q88 >= -11'sd512) && (value_q88 <= 11'sd512))
        else $error("result outside the Q8.8 clamp range");

    a_clear_on_enter : assert property (@(posedge clk) disable iff (!rst_n)
        (stage_go && is_enter) |=> (entry_state == '0))
        else $error("entry state not cleared after enter");

    a_fraction_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (entry_state.fraction_digits <= 2'd2) && (entry_state.fraction_part <= 7'd99))
        else $error("fraction accumulator out of range");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        key_stall |-> (is_enter && value_valid_reg && value_stall))
        else $error("input stalled without a blocked enter");

endmodule

// File: test/keypad_decimal_to_q8_8_parser_tb.sv
// Self-checking testbench for the keypad decimal entry parser with Q8.8 output.
`timescale 1ns / 1ps

module keypad_decimal_to_q8_8_parser_tb;

    localparam int KEY_TARGET    = 650;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;

    // Tracks the entry state of the keypad, predicts each Q8.8 value and
    // compares the values that leave the block against the predictions.
    class q88_entry_checker;
        logic [9:0]        int_acc;
        logic [6:0]        frac_acc;
        logic [1:0]        frac_count;
        bit                minus;
        bit                point;
        bit                digit;
        logic signed [10:0] expected_values[$];
        int unsigned       mismatches;
        int unsigned       values_checked;
        int unsigned       negative_values;
        int unsigned       clamped_values;

        function new();
            clear_entry();
            mismatches      = 0;
            values_checked  = 0;
            negative_values = 0;
            clamped_values  = 0;
        endfunction

        function void clear_entry();
            int_acc    = '0;
            frac_acc   = '0;
            frac_count = '0;
            minus      = 1'b0;
            point      = 1'b0;
            digit      = 1'b0;
        endfunction

        function logic signed [10:0] compose_q88();
            int q;
            q = int'(int_acc) << 8;
            if (frac_count == 2'd1)
                q += (int'(frac_acc) << 8) / 10;
            else if (frac_count == 2'd2)
                q += (int'(frac_acc) << 8) / 100;
            if (minus)
                q = -q;
            if (q < -int'(kpq_pkg::Q_MAX_MAG))
                q = -int'(kpq_pkg::Q_MAX_MAG);
            if (q > int'(kpq_pkg::Q_MAX_MAG))
                q = int'(kpq_pkg::Q_MAX_MAG);
            return q[10:0];
        endfunction

        // Called for every key transaction accepted by the block.
        function void take_key(logic [7:0] k);
            int v;
            if (k == kpq_pkg::KEY_ENTER) begin
                expected_values.push_back(compose_q88());
                clear_entry();
            end
            else if (k == kpq_pkg::KEY_STAR) begin
                if (!digit && !minus)
                    minus = 1'b1;
                else if (digit && !point)
                    point = 1'b1;
            end
            else if (k >= kpq_pkg::KEY_ZERO && k <= kpq_pkg::KEY_NINE) begin
                digit = 1'b1;
                if (point) begin
                    if (frac_count < 2'd2) begin
                        frac_acc   = frac_acc * 7'd10 + 7'(k - kpq_pkg::KEY_ZERO);
                        frac_count = frac_count + 2'd1;
                    end
                end
                else begin
                    v = int'(int_acc) * 10 + int'(k - kpq_pkg::KEY_ZERO);
                    int_acc = (v > int'(kpq_pkg::INT_MAX_ACC)) ? kpq_pkg::INT_MAX_ACC
                                                                : v[9:0];
                end
            end
        endfunction

        // Called for every value transaction accepted from the block.
        function void match_value(logic signed [10:0] actual);
            logic signed [10:0] want;
            if (expected_values.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected value %0d with no prediction waiting", actual);
                return;
            end
            want = expected_values.pop_front();
            values_checked++;
            if (want < 0)
                negative_values++;
            if (want == 11'sd512 || want == -11'sd512)
                clamped_values++;
            if (actual !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("value_q88 mismatch: expected %0d, got %0d", want, actual);
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic [7:0]         key_code = 8'h00;
    logic               key_valid = 1'b0;
    logic               key_stall;
    logic signed [10:0] value_q88;
    logic               value_valid;
    logic               value_stall = 1'b0;

    q88_entry_checker   checker_h = new();
    int unsigned        burst_left = 0;
    int unsigned        keys_counted = 0;
    int unsigned        keys_sent = 0;
    bit                 hold_req = 1'b0;
    bit                 hold_done = 1'b0;

    keypad_decimal_to_q8_8_parser i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_code    (key_code),
        .key_valid   (key_valid),
        .key_stall   (key_stall),
        .value_q88   (value_q88),
        .value_valid (value_valid),
        .value_stall (value_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one key and returns at the edge where it is accepted. The sender
    // works in bursts, dropping valid for a random gap between them.
    task automatic send_key(input logic [7:0] k);
        if (burst_left == 0) begin
            key_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        key_code  <= k;
        key_valid <= 1'b1;
        do
            @(posedge clk);
        while (key_stall);
        checker_h.take_key(k);
        keys_sent++;
        if (k == kpq_pkg::KEY_ENTER || k == kpq_pkg::KEY_STAR ||
            (k >= kpq_pkg::KEY_ZERO && k <= kpq_pkg::KEY_NINE))
            keys_counted++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_key(s[i]);
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 99) < 8)
            send_key(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 99) < 5)
            send_key(kpq_pkg::KEY_STAR);
    endtask

    task automatic send_digit(input bit near_range);
        send_key(kpq_pkg::KEY_ZERO +
                 8'(near_range ? $urandom_range(0, 2) : $urandom_range(0, 9)));
    endtask

    // One number as a user would type it, with occasional stray keys mixed
    // in and now and then a missing enter so entries run together.
    task automatic send_number();
        int n_int;
        int n_frac;
        int pick;
        if ($urandom_range(0, 99) < 40)
            send_key(kpq_pkg::KEY_STAR);
        send_noise();
        pick = $urandom_range(0, 99);
        if (pick < 15)
            n_int = 0;
        else if (pick < 70)
            n_int = 1;
        else if (pick < 85)
            n_int = 2;
        else
            n_int = $urandom_range(3, 5);
        for (int i = 0; i < n_int; i++) begin
            send_digit(n_int == 1);
            send_noise();
        end
        if ($urandom_range(0, 99) < 60) begin
            send_key(kpq_pkg::KEY_STAR);
            n_frac = $urandom_range(0, 3);
            for (int i = 0; i < n_frac; i++) begin
                send_digit(1'b0);
                send_noise();
            end
        end
        if ($urandom_range(0, 9) != 0)
            send_key(kpq_pkg::KEY_ENTER);
    endtask

    // Result side: checks each accepted value and stalls on a pattern that
    // changes from phase to phase, with one long hold-off on request.
    initial
    begin
        int unsigned cyc;
        int unsigned hold_left;
        cyc = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (value_valid && !value_stall)
                checker_h.match_value(value_q88);
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                value_stall <= 1'b1;
            end
            else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                value_stall <= 1'b1;
            end
            else begin
                case ((cyc / 97) % 4)
                    0: value_stall <= 1'b0;
                    1: value_stall <= ($urandom_range(0, 3) == 0);
                    2: value_stall <= ($urandom_range(0, 9) < 7);
                    default: value_stall <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    // Ends the run when neither channel moves a transaction for too long.
    initial
    begin
        int unsigned idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if ((key_valid && !key_stall) || (value_valid && !value_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles, %0d values pending",
                         idle, checker_h.pending());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed entries: empty enter, negative with two fraction digits,
        // a saturating integer, no key and an unknown code, stray stars with
        // a dropped third fraction digit, and a single fraction digit.
        send_text("#");
        send_text("*1*99#");
        send_text("9999#");
        send_key(8'h00);
        send_key(8'hFF);
        send_text("**1**234#");
        send_text("1*5#");

        while (keys_counted < KEY_TARGET) begin
            if (!hold_done && keys_counted > 200) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            send_number();
        end
        key_valid <= 1'b0;

        while (checker_h.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d keys; checked %0d values, %0d negative and %0d at a clamp limit.",
                 keys_sent, checker_h.values_checked, checker_h.negative_values,
                 checker_h.clamped_values);
        if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
            $display("status: pass");
        end
        else begin
            $display("%0d mismatches, %0d values never arrived",
                     checker_h.mismatches, checker_h.pending());
            $display("status: fail");
        end
        $finish;
    end

endmodule
